/* design/c3zp_pkg.sv */
// ============================================================================
// c3zp_pkg: shared constants and types of the 3x3 RGB convolution filter
// Geometry limits, field widths, configuration register indexes and the
// control words that travel between the filter's pipeline stages.
// ============================================================================
`default_nettype none

package c3zp_pkg;

    // Geometry and coefficient format.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COEF_BITS  = 16;

    // Fixed field widths.
    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int PIX_W      = NCH * CH_W;
    localparam int SLOT_W     = 16;
    localparam int NROW       = 3;
    localparam int NCOL       = 3;
    localparam int NTAP       = NROW * NCOL;
    localparam int COEF_ROW_W = NCOL * SLOT_W;
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int FRAC_BITS  = 7;

    // Derived widths.
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W  = $clog2(MAX_WIDTH + 2);
    localparam int RAM_W   = 2 * PIX_W;
    localparam int PROD_W  = CH_W + SLOT_W;
    localparam int SUM_W   = PROD_W + $clog2(NTAP);

    // Reset values of the configuration registers.
    localparam int RESET_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RESET_HEIGHT = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
    localparam logic [COEF_ROW_W-1:0] COEF_TOP_RESET = '0;
    localparam logic [COEF_ROW_W-1:0] COEF_MID_RESET = 48'h0000_0080_0000;
    localparam logic [COEF_ROW_W-1:0] COEF_BOT_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_TOP     = 3'd2,
        CFG_COEF_MID     = 3'd3,
        CFG_COEF_BOTTOM  = 3'd4
    } t_cfg_idx;

    typedef logic [PIX_W-1:0]                     t_pix;
    typedef logic [NROW-1:0][COEF_ROW_W-1:0]      t_coef_rows;
    typedef logic [PROD_W-1:0]                    t_prod;
    typedef t_prod [NCH-1:0][NTAP-1:0]            t_prods;

    // Decisions made for an item when it is accepted.
    typedef struct packed {
        logic              keep_pix;
        logic              emit;
        logic              last;
        logic              wrap;
        logic              top_zero;
        logic              bot_zero;
        logic              left_zero;
        logic              right_zero;
        logic [ADDR_W-1:0] addr;
    } t_item_ctl;

    // Line store write request.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [RAM_W-1:0]  data;
    } t_ram_wr;

    // Products of one output pixel on their way to the adder stage.
    typedef struct packed {
        logic   last;
        t_prods prods;
    } t_prod_word;

endpackage

`default_nettype wire

/* design/c3zp_pix_if.sv */
// ============================================================================
// c3zp_pix_if: pixel input channel
// Valid/ready channel that carries one pixel or drain word.
// ============================================================================
`default_nettype none

interface c3zp_pix_if import c3zp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            func;
    logic [CH_W-1:0] pix_r;
    logic [CH_W-1:0] pix_g;
    logic [CH_W-1:0] pix_b;

    modport source (output valid, output func, output pix_r, output pix_g, output pix_b,
                    input ready);
    modport sink   (input valid, input func, input pix_r, input pix_g, input pix_b,
                    output ready);
endinterface

`default_nettype wire

/* design/c3zp_res_if.sv */
// ============================================================================
// c3zp_res_if: filtered pixel output channel
// Valid/ready channel that carries one filtered pixel and its end-of-frame flag.
// ============================================================================
`default_nettype none

interface c3zp_res_if import c3zp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_r;
    logic [CH_W-1:0] out_g;
    logic [CH_W-1:0] out_b;
    logic            out_last;

    modport source (output valid, output out_r, output out_g, output out_b,
                    output out_last, input ready);
    modport sink   (input valid, input out_r, input out_g, input out_b,
                    input out_last, output ready);
endinterface

`default_nettype wire

/* design/c3zp_cfg_if.sv */
// ============================================================================
// c3zp_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ============================================================================
`default_nettype none

interface c3zp_cfg_if import c3zp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/c3zp_ram.sv */
// ============================================================================
// c3zp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data. A read of the
// address being written in the same cycle returns the old contents.
// ============================================================================
`default_nettype none

module c3zp_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/c3zp_ctrl.sv */
// ============================================================================
// c3zp_ctrl: configuration registers and frame position tracking
// Holds geometry and coefficients, tracks input and output positions, and
// decides for each accepted word whether it completes an output pixel.
// ============================================================================
`default_nettype none

module c3zp_ctrl import c3zp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    c3zp_cfg_if.sink    cfg,
    input  wire logic   i_accept,
    input  wire logic   i_func,
    output t_item_ctl   o_ctl,
    output t_coef_rows  o_coef
);

    logic [WID_W-1:0]  r_width,   n_width;
    logic [HGT_W-1:0]  r_height,  n_height;
    t_coef_rows        r_coef,    n_coef;
    logic [ADDR_W-1:0] r_in_col,  n_in_col;
    logic [HGT_W-1:0]  r_in_row,  n_in_row;
    logic [ADDR_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [PEND_W-1:0] r_pending, n_pending;

    logic              cfg_we;
    logic [WCFG_W-1:0] cfg_w;
    logic [HCFG_W-1:0] cfg_h;
    logic [ADDR_W-1:0] cur_col;
    logic              in_row_end;
    logic              in_frame;
    logic              emit;
    logic              out_col_end;
    logic              out_row_end;
    logic              last;
    logic              restart;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;
    assign cfg_w     = cfg.data[WCFG_W-1:0];
    assign cfg_h     = cfg.data[HCFG_W-1:0];

    always_comb begin
        cur_col     = (WID_W'(r_in_col) < r_width) ? r_in_col : '0;
        in_row_end  = (WID_W'(cur_col) + WID_W'(1)) >= r_width;
        in_frame    = r_in_row < r_height;
        emit        = (r_pending >= (PEND_W'(r_width) + PEND_W'(1)))
                      && (HGT_W'(r_out_row) < r_height);
        out_col_end = (WID_W'(r_out_col) + WID_W'(1)) >= r_width;
        out_row_end = (HGT_W'(r_out_row) + HGT_W'(1)) >= r_height;
        last        = out_col_end && out_row_end;

        o_ctl.keep_pix   = !i_func && in_frame;
        o_ctl.emit       = emit;
        o_ctl.last       = last;
        o_ctl.wrap       = (cur_col == '0);
        o_ctl.top_zero   = (r_out_row == '0);
        o_ctl.bot_zero   = out_row_end;
        o_ctl.left_zero  = (r_out_col == '0);
        o_ctl.right_zero = out_col_end;
        o_ctl.addr       = cur_col;
    end

    assign o_coef = r_coef;

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_coef    = r_coef;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pending = r_pending;
        restart   = 1'b0;

        if (cfg_we) begin
            case (t_cfg_idx'(cfg.index))
                CFG_IMAGE_WIDTH: begin
                    if (cfg_w == '0) begin
                        n_width = WID_W'(1);
                    end else if (cfg_w > MAX_WIDTH) begin
                        n_width = WID_W'(MAX_WIDTH);
                    end else begin
                        n_width = WID_W'(cfg_w);
                    end
                    restart = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    if (cfg_h == '0) begin
                        n_height = HGT_W'(1);
                    end else if (cfg_h > MAX_HEIGHT) begin
                        n_height = HGT_W'(MAX_HEIGHT);
                    end else begin
                        n_height = HGT_W'(cfg_h);
                    end
                    restart = 1'b1;
                end
                CFG_COEF_TOP:    n_coef[0] = cfg.data[COEF_ROW_W-1:0];
                CFG_COEF_MID:    n_coef[1] = cfg.data[COEF_ROW_W-1:0];
                CFG_COEF_BOTTOM: n_coef[2] = cfg.data[COEF_ROW_W-1:0];
                default: ;
            endcase
        end else if (i_accept) begin
            if (emit) begin
                if (last) begin
                    restart = 1'b1;
                end else if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + ADDR_W'(1);
                end
            end else begin
                n_pending = r_pending + PEND_W'(1);
            end
            if (!(emit && last)) begin
                if (in_row_end) begin
                    n_in_col = '0;
                    // The row count stops at the frame height; only "inside
                    // the frame or not" matters past that point.
                    if (in_frame) begin
                        n_in_row = r_in_row + HGT_W'(1);
                    end
                end else begin
                    n_in_col = cur_col + ADDR_W'(1);
                end
            end
        end

        if (restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_pending = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WID_W'(RESET_WIDTH);
            r_height  <= HGT_W'(RESET_HEIGHT);
            r_coef    <= {COEF_BOT_RESET, COEF_MID_RESET, COEF_TOP_RESET};
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_coef    <= n_coef;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

/* design/c3zp_window.sv */
// ============================================================================
// c3zp_window: column stage, 3x3 window and coefficient products
// Takes the line store column read for the accepted word, shifts the window,
// writes the column back and forms the 27 pixel-by-coefficient products.
// ============================================================================
`default_nettype none

module c3zp_window import c3zp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire t_item_ctl        i_ctl,
    input  wire t_pix             i_pix,
    input  wire logic [RAM_W-1:0] i_rdata,
    input  wire t_coef_rows       i_coef,
    input  wire logic             i_s2_free,
    output      logic             o_in_ready,
    output t_ram_wr               o_ram_wr,
    output      logic             o_load,
    output t_prod_word            o_word
);

    logic             r_s1_v;
    t_item_ctl        r_s1_ctl;
    t_pix             r_s1_pix;
    logic             r_fwd;
    logic [RAM_W-1:0] r_fwd_data;
    t_pix [NTAP-1:0]  r_win, n_win;

    t_pix [NTAP-1:0]  taps;
    logic [RAM_W-1:0] col_word;
    t_pix             col_up;
    t_pix             col_low;
    logic             s1_adv;
    t_prods           prods;

    function automatic logic signed [SLOT_W-1:0] coef_at(
        input logic [COEF_ROW_W-1:0] row_word,
        input int                    col
    );
        logic [SLOT_W-1:0] slot;
        slot = row_word[col*SLOT_W +: SLOT_W];
        return SLOT_W'(signed'(slot[COEF_BITS-1:0]));
    endfunction

    function automatic t_prod chan_prod(
        input logic        [CH_W-1:0]   pix,
        input logic signed [SLOT_W-1:0] coef
    );
        logic signed [PROD_W:0] full;
        full = $signed({1'b0, pix}) * coef;
        return full[PROD_W-1:0];
    endfunction

    assign s1_adv     = r_s1_v && (!r_s1_ctl.emit || i_s2_free);
    assign o_in_ready = !r_s1_v || s1_adv;

    always_comb begin
        // With a one-pixel row the column just written is read again at once.
        col_word = r_fwd ? r_fwd_data : i_rdata;
        col_up   = col_word[RAM_W-1:PIX_W];
        col_low  = col_word[PIX_W-1:0];

        for (int r = 0; r < NROW; r++) begin
            for (int c = 0; c < NCOL - 1; c++) begin
                n_win[r*NCOL + c] = r_win[r*NCOL + c + 1];
            end
        end
        n_win[NCOL-1]        = col_up;
        n_win[2*NCOL-1]      = col_low;
        n_win[NROW*NCOL-1]   = r_s1_pix;

        // At the first input column the finished output lies at the end of
        // the previous row, which is the window before this shift.
        taps = n_win;
        if (r_s1_ctl.wrap) begin
            for (int r = 0; r < NROW; r++) begin
                for (int c = 0; c < NCOL - 1; c++) begin
                    taps[r*NCOL + c] = r_win[r*NCOL + c + 1];
                end
                taps[r*NCOL + NCOL - 1] = '0;
            end
        end

        // Neighbors outside the image count as zero.
        for (int c = 0; c < NCOL; c++) begin
            if (r_s1_ctl.top_zero) begin
                taps[c] = '0;
            end
            if (r_s1_ctl.bot_zero) begin
                taps[(NROW-1)*NCOL + c] = '0;
            end
        end
        for (int r = 0; r < NROW; r++) begin
            if (r_s1_ctl.left_zero) begin
                taps[r*NCOL] = '0;
            end
            if (r_s1_ctl.right_zero) begin
                taps[r*NCOL + NCOL - 1] = '0;
            end
        end

        for (int r = 0; r < NROW; r++) begin
            for (int c = 0; c < NCOL; c++) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    prods[ch][r*NCOL + c] = chan_prod(taps[r*NCOL + c][ch*CH_W +: CH_W],
                                                      coef_at(i_coef[r], c));
                end
            end
        end
    end

    always_comb begin
        o_ram_wr.we   = s1_adv;
        o_ram_wr.addr = r_s1_ctl.addr;
        o_ram_wr.data = {col_low, r_s1_pix};
    end

    assign o_load = s1_adv && r_s1_ctl.emit;
    assign o_word = {r_s1_ctl.last, prods};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
            r_win  <= '0;
        end else begin
            if (i_accept) begin
                r_s1_v <= 1'b1;
                r_fwd  <= s1_adv && (r_s1_ctl.addr == i_ctl.addr);
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ctl   <= i_ctl;
            r_s1_pix   <= i_ctl.keep_pix ? i_pix : '0;
            r_fwd_data <= o_ram_wr.data;
        end
    end

endmodule

`default_nettype wire

/* design/c3zp_accum.sv */
// ============================================================================
// c3zp_accum: product summation, scaling and clipping
// Adds the nine products of each channel, scales by 1/128 toward zero,
// clips to 0..255 and holds the result word for the output channel.
// ============================================================================
`default_nettype none

module c3zp_accum import c3zp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_prod_word i_word,
    output      logic       o_s2_free,
    c3zp_res_if.source      res
);

    logic                       r_s2_v;
    t_prod_word                 r_s2_word;
    logic                       r_out_v;
    logic [NCH-1:0][CH_W-1:0]   r_out_ch, n_out_ch;
    logic                       r_out_last;

    logic                       out_free;
    logic                       out_load;
    logic signed [SUM_W-1:0]    sum;

    // Negative sums clip to zero, so truncation toward zero reduces to a
    // shift of non-negative values.
    function automatic logic [CH_W-1:0] clip_sum(input logic signed [SUM_W-1:0] s);
        logic [CH_W-1:0] q;
        if (s[SUM_W-1]) begin
            q = '0;
        end else if (|s[SUM_W-2:FRAC_BITS+CH_W]) begin
            q = '1;
        end else begin
            q = s[FRAC_BITS +: CH_W];
        end
        return q;
    endfunction

    assign out_free  = !r_out_v || res.ready;
    assign out_load  = r_s2_v && out_free;
    assign o_s2_free = !r_s2_v || out_free;

    always_comb begin
        sum = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            sum = '0;
            for (int k = 0; k < NTAP; k++) begin
                sum = sum + SUM_W'($signed(r_s2_word.prods[ch][k]));
            end
            n_out_ch[ch] = clip_sum(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_load) begin
                r_s2_v <= 1'b1;
            end else if (out_load) begin
                r_s2_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s2_word <= i_word;
        end
        if (out_load) begin
            r_out_ch   <= n_out_ch;
            r_out_last <= r_s2_word.last;
        end
    end

    assign res.valid    = r_out_v;
    assign res.out_r    = r_out_ch[0];
    assign res.out_g    = r_out_ch[1];
    assign res.out_b    = r_out_ch[2];
    assign res.out_last = r_out_last;

endmodule

`default_nettype wire

/* design/conv3x3_rgb_zero_pad.sv */
// ============================================================================
// conv3x3_rgb_zero_pad: streaming 3x3 RGB convolution with zero padding
// Pixels enter on i_pix in raster order. Each word completes the output pixel
// one row and one pixel behind it; after a frame, width+1 drain words
// (func = 1) flush the rest, and the final output carries out_last.
// Filtered pixels leave on o_res. Registers are written on i_cfg: index 0
// image width, 1 image height (both restart the frame), 2..4 the coefficient
// rows top, middle, bottom. Write the registers only while the block is idle.
// Throughput is one word per clock while the window stage is not held by a
// full adder stage. The line store read and window products are registered
// in the adder stage, and the adder tree and clip in the output register that
// presents the result word on o_res.
// When o_res stalls, the result waits in the output register and words keep
// being accepted until the adder stage and the window stage are both full;
// words that complete no output never wait on o_res.
// Reset restores a 1024x1024 frame with the identity kernel and clears all
// positions and the window; the line stores are not cleared.
// ============================================================================
`default_nettype none

module conv3x3_rgb_zero_pad import c3zp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    c3zp_pix_if.sink    i_pix,
    c3zp_res_if.source  o_res,
    c3zp_cfg_if.sink    i_cfg
);

    logic             accept;
    t_item_ctl        item_ctl;
    t_coef_rows       coef;
    t_pix             pix;
    logic [RAM_W-1:0] ram_rdata;
    t_ram_wr          ram_wr;
    logic             in_ready;
    logic             s2_free;
    logic             s2_load;
    t_prod_word       prod_word;

    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;
    assign pix         = {i_pix.pix_b, i_pix.pix_g, i_pix.pix_r};

    c3zp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .cfg      (i_cfg),
        .i_accept (accept),
        .i_func   (i_pix.func),
        .o_ctl    (item_ctl),
        .o_coef   (coef)
    );

    // Each word holds the column pair {upper line, lower line}.
    c3zp_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (accept),
        .i_raddr (item_ctl.addr),
        .o_rdata (ram_rdata)
    );

    c3zp_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_ctl      (item_ctl),
        .i_pix      (pix),
        .i_rdata    (ram_rdata),
        .i_coef     (coef),
        .i_s2_free  (s2_free),
        .o_in_ready (in_ready),
        .o_ram_wr   (ram_wr),
        .o_load     (s2_load),
        .o_word     (prod_word)
    );

    c3zp_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s2_load),
        .i_word    (prod_word),
        .o_s2_free (s2_free),
        .res       (o_res)
    );

endmodule

`default_nettype wire
